[hdl/assert_macros.svh]
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

[hdl/modexp_pkg.sv]
package modexp_pkg;

  localparam int unsigned DATA_W = 31;
  localparam int unsigned MOD_WIDTH_DEF = 31;

  localparam logic [DATA_W-1:0] MODULUS_RST = DATA_W'(25101919);
  localparam logic [DATA_W-1:0] EXPONENT_RST = DATA_W'(3);

  // configuration register indexes
  typedef enum logic {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_idx_e;

  // data moving from one multiplier cell to the next
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] r;   // partial product, reduced
    logic [DATA_W-1:0] a;   // multiplicand, below the modulus
    logic [DATA_W-1:0] b;   // multiplier, msb consumed first
  } stage_t;

endpackage

[hdl/modexp_cell.sv]
module modexp_cell
  import modexp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] mod_i,
  input  stage_t            stage_i,
  output stage_t            stage_o
);

  logic [DATA_W+1:0] sum;
  logic [DATA_W+1:0] m1;
  logic [DATA_W+1:0] m2;
  logic [DATA_W+1:0] red;
  stage_t            stage_d;
  stage_t            stage_q;

  // one interleaved step: r = 2r + bit*a, then bring back below m (sum < 3m)
  always_comb begin
    m1  = {2'b00, mod_i};
    m2  = {1'b0, mod_i, 1'b0};
    sum = {1'b0, stage_i.r, 1'b0} + (stage_i.b[DATA_W-1] ? {2'b00, stage_i.a} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
    stage_d     = stage_i;
    stage_d.r   = red[DATA_W-1:0];
    stage_d.b   = {stage_i.b[DATA_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

[hdl/modexp_chain.sv]
module modexp_chain
  import modexp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] mod_i,
  input  stage_t            head_i,
  output stage_t            tail_o
);

  stage_t link [DATA_W+1];

  assign link[0] = head_i;

  // one cell per multiplier bit
  for (genvar k = 0; k < DATA_W; k++) begin : g_cell
    modexp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mod_i   (mod_i),
      .stage_i (link[k]),
      .stage_o (link[k+1])
    );
  end

  assign tail_o = link[DATA_W];

endmodule

[hdl/modular_exponentiation_top.sv]
// Modular exponentiation, right-to-left square and multiply.
// Config channel: cfg_index_i selects modulus (0) or exponent (1); written
//   with cfg_valid_i, always ready. Write only while the block is idle.
// Input: base_value_i with in_valid_i / in_ready_o; one item at a time.
// Output: power_result_o with out_valid_o / out_ready_i, held until taken.
// Each modular product runs through a row of 31 cells, one multiplier bit
// per cell. The base reduction takes one pass; each exponent bit up to the
// highest set one takes one more pass, square and multiply running side by
// side in two rows.
// Modulus below two: result 0 is valid the cycle after the input transaction.
// A stalled receiver holds the result and blocks new input until taken.
// Reset: modulus 25101919, exponent 3, both rows empty, block idle.
`include "assert_macros.svh"
module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] base_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] power_result_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_LOOP = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  localparam logic [DATA_W-1:0] ModMask = DATA_W'((64'd1 << MOD_WIDTH) - 64'd1);
  localparam logic [DATA_W-1:0] One = DATA_W'(1);

  state_e            state_q, state_d;
  logic [DATA_W-1:0] modulus_q, exponent_q;
  logic [DATA_W-1:0] exp_q, exp_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] sq_q, sq_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] mod_eff;
  logic              launch;
  logic [DATA_W-1:0] mul_a, mul_b;
  stage_t            head_mul, head_sq, tail_mul, tail_sq;

  assign mod_eff     = modulus_q & ModMask;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST;
      exponent_q <= EXPONENT_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MODULUS:  modulus_q  <= cfg_data_i;
        REG_EXPONENT: exponent_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    exp_d   = exp_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    res_d   = res_q;
    launch  = 1'b0;
    mul_a   = acc_q;
    mul_b   = sq_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mod_eff < DATA_W'(2)) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            acc_d   = One;
            exp_d   = exponent_q;
            launch  = 1'b1;
            mul_a   = One;
            mul_b   = base_value_i;
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        if (tail_mul.vld) begin
          sq_d = tail_mul.r;
          if (exp_q == '0) begin
            res_d   = acc_q;
            state_d = S_DONE;
          end else begin
            launch  = 1'b1;
            mul_a   = acc_q;
            mul_b   = sq_d;
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (tail_mul.vld) begin
          if (exp_q[0]) begin
            acc_d = tail_mul.r;
          end
          sq_d  = tail_sq.r;
          exp_d = exp_q >> 1;
          if (exp_d == '0) begin
            res_d   = acc_d;
            state_d = S_DONE;
          end else begin
            launch = 1'b1;
            mul_a  = acc_d;
            mul_b  = sq_d;
          end
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    res_q <= res_d;
  end

  // multiply row (also reduces the base) and squaring row
  assign head_mul = '{vld: launch, r: '0, a: mul_a, b: mul_b};
  assign head_sq  = '{vld: launch && (state_q != S_IDLE), r: '0, a: sq_d, b: sq_d};

  modexp_chain u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_eff),
    .head_i (head_mul),
    .tail_o (tail_mul)
  );

  modexp_chain u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_eff),
    .head_i (head_sq),
    .tail_o (tail_sq)
  );

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_DONE);
  assign power_result_o = res_q;

  `ASSERT_NEVER(a_ready_and_valid, clk_i, rst_ni, in_ready_o && out_valid_o,
                "input ready while a result waits")
  `ASSERT_CHK(a_tail_when_busy, clk_i, rst_ni,
              tail_mul.vld |-> (state_q == S_PREP || state_q == S_LOOP),
              "product left the row while no item is in work")
  `ASSERT_CHK(a_rows_in_step, clk_i, rst_ni,
              (state_q == S_LOOP && tail_mul.vld) |-> tail_sq.vld,
              "multiply and square rows out of step")
  `ASSERT_CHK(a_result_reduced, clk_i, rst_ni,
              (out_valid_o && mod_eff >= DATA_W'(2)) |-> (power_result_o < mod_eff),
              "result not below modulus")

endmodule

[test/modexp_checker.sv]
module modexp_checker
  import modexp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [DATA_W-1:0] base_value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [DATA_W-1:0] power_result_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o,
  output int unsigned       result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] modulus_q;
  logic [DATA_W-1:0] exponent_q;
  logic [DATA_W-1:0] power_queue[$];

  // base ^ exp mod m, square and multiply from the low exponent bit up
  function automatic logic [DATA_W-1:0] calc_power(logic [DATA_W-1:0] base,
                                                   logic [DATA_W-1:0] exp,
                                                   logic [DATA_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    if (m == '0) return '0;
    mm = 64'(m);
    acc = 64'd1 % mm;
    sq = 64'(base) % mm;
    for (int i = 0; i < DATA_W; i++) begin
      if (exp[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[DATA_W-1:0];
  endfunction

  assign pending_o = power_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      exponent_q <= EXPONENT_RST;
      error_count_o <= 0;
      result_count_o <= 0;
      power_queue.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MODULUS) modulus_q <= cfg_data_i;
        else exponent_q <= cfg_data_i;
      end
      // accepted base transaction
      if (in_valid_i && in_ready_i)
        power_queue = {power_queue, calc_power(base_value_i, exponent_q, modulus_q)};
      // accepted result transaction
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (power_queue.size() == 0) begin
          $error("unexpected power_result %0d", power_result_i);
          error_count_o <= error_count_o + 1;
        end else begin
          if (power_result_i !== power_queue[0]) begin
            $error("power_result: expected %0d, actual %0d", power_queue[0],
                   power_result_i);
            error_count_o <= error_count_o + 1;
          end
          void'(power_queue.pop_front());
        end
      end
    end
  end
endmodule

[test/tb_modular_exponentiation_top.sv]
module tb_modular_exponentiation_top;
  import modexp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = REG_MODULUS;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [DATA_W-1:0] base_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] power_result_o;
  int unsigned       error_count;
  int unsigned       pending;
  int unsigned       result_count;
  int unsigned       cycle_count = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       base_count = 0;
  int unsigned       setting_count = 0;

  modular_exponentiation_top i_dut (.*);

  modexp_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o), .base_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .power_result_i(power_result_o),
    .error_count_o(error_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // cycle limit watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // valid stays up after the transaction; the caller drops it
  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // valid stays up after the transaction; idling or drain() drops it
  task automatic send_base(logic [DATA_W-1:0] base);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_value_i <= base;
    do @(posedge clk_i); while (!in_ready_o);
    base_count++;
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [DATA_W-1:0] m, logic [DATA_W-1:0] e);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_EXPONENT, e);
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    w = DATA_W'($urandom());
    case ($urandom_range(3))
      0: w = w >> $urandom_range(DATA_W - 1);
      1: w = '1 >> $urandom_range(3);
      default: ;
    endcase
    return w;
  endfunction

  // small exponents keep most items short
  function automatic logic [DATA_W-1:0] rand_exp();
    if ($urandom_range(9) == 0) return rand_word();
    return DATA_W'($urandom_range(255));
  endfunction

  initial begin
    logic [DATA_W-1:0] m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, field extremes, special moduli/exponents
    send_base('0);
    send_base(DATA_W'(1));
    send_base('1);
    send_base(DATA_W'(65));
    set_mode('1, '1);
    send_base('1);
    send_base(DATA_W'(2));
    send_base('0);
    set_mode(DATA_W'(1000003), '0);
    send_base('0);
    send_base(DATA_W'(12345));
    set_mode(DATA_W'(1), '0);
    send_base(DATA_W'(7));
    set_mode(DATA_W'(1), DATA_W'(5));
    send_base('1);
    set_mode('0, DATA_W'(9));
    send_base(DATA_W'(77));
    send_base('1);
    set_mode(DATA_W'(2), '1);
    send_base(DATA_W'(3));
    send_base(DATA_W'(4));
    set_mode(DATA_W'(2147483629), DATA_W'(65537));
    send_base(DATA_W'(1234567890));
    send_base(DATA_W'(2147483640));

    // random phases with varying idle and stall pressure
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      case ($urandom_range(5))
        0: m = DATA_W'($urandom_range(3));
        1: m = '1;
        default: m = rand_word();
      endcase
      set_mode(m, rand_exp());
      for (int k = 0; k < 33; k++) send_base(rand_word());
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();

    $display("Covered %0d bases over %0d register settings, %0d results checked.",
             base_count, setting_count, result_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
